>>> hw/rtl/nfsa_pkg.sv
// shared constants and types for the next-fit slot allocator
package nfsa_pkg;

	// pointer and pool size width, holds sizes up to 511
	localparam int PTR_W   = 9;
	// free map is kept as words of sixteen slot bits
	localparam int WORD_W  = 16;
	localparam int BIT_W   = 4;
	// word number of any slot below 512
	localparam int WIDX_W  = PTR_W - BIT_W;
	localparam int SLOT_W  = 8;
	localparam int STAT_W  = 2;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EXHAUSTED = 2'd1;
	localparam status_t ST_RANGE     = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

>>> hw/rtl/nfsa_if.sv
// request, response and configuration channels of the slot allocator

interface nfsa_req_if;
	import nfsa_pkg::*;
	logic              valid;
	logic              ready;
	logic              func;
	logic [SLOT_W-1:0] slot_index;
	modport source (output valid, output func, output slot_index, input ready);
	modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface nfsa_rsp_if;
	import nfsa_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] granted_index;
	status_t           status;
	modport source (output valid, output granted_index, output status, input ready);
	modport sink   (input valid, input granted_index, input status, output ready);
endinterface

interface nfsa_cfg_if;
	import nfsa_pkg::*;
	logic             valid;
	logic             ready;
	logic [PTR_W-1:0] pool_size;
	modport source (output valid, output pool_size, input ready);
	modport sink   (input valid, input pool_size, output ready);
endinterface

>>> hw/rtl/next_fit_slot_allocator.sv
// next-fit slot allocator: word-serial scan of a free map memory
//
// Usage: requests arrive on req (func 0 allocate, func 1 free slot_index),
// one response per request leaves on rsp (granted_index, status). The pool
// size register is written through cfg, which is always ready; write it
// only while no request is outstanding.
// Operation: a free of an in-range slot reads its map word and writes it
// back with the slot bit set. An allocate tests one sixteen-slot word at a
// time, starting at the pointer and stopping at the first free slot or at
// the word that holds the end of the pool. Out-of-range frees and allocates
// with an empty scan range answer straight from idle. One request is in
// flight at a time; the single read port of the free map memory and the
// one-word test unit set the scan rate.
// The response sits in an output register: a new request is taken while it
// waits only if the receiver takes it in the same cycle, otherwise req is
// held not ready until the beat goes out.
// Reset: the pointer clears, pool size becomes 256, then a clearing pass
// writes every map word to all free, with req not ready during it.
module next_fit_slot_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	nfsa_req_if.sink    req,
	nfsa_rsp_if.source  rsp,
	nfsa_cfg_if.sink    cfg
);
	import nfsa_pkg::*;

	localparam int NW       = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
	localparam int SIZE_CAP = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FREE  = 2'd3;

	logic [1:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  pool_size_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] granted_q;
	status_t           status_q;
	logic [WIDX_W-1:0] word_q;
	logic [BIT_W-1:0]  start_q;
	logic [BIT_W-1:0]  fbit_q;

	logic [WORD_W-1:0] mem [NW];
	logic [WORD_W-1:0] rdata_q;

	logic              accept;
	logic [PTR_W-1:0]  size_w;
	logic [PTR_W-1:0]  ptr_wrap;
	logic [WIDX_W-1:0] rd_word;
	logic              we;
	logic [AW-1:0]     wa;
	logic [WORD_W-1:0] wd;
	logic [WORD_W-1:0] cand;
	logic              hit;
	logic [BIT_W-1:0]  hit_bit;
	logic [PTR_W-1:0]  hit_idx;
	logic              last_word;
	logic              rsp_load;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_index = granted_q;
	assign rsp.status        = status_q;

	assign size_w   = (pool_size_q < PTR_W'(SIZE_CAP)) ? pool_size_q : PTR_W'(SIZE_CAP);
	assign ptr_wrap = (ptr_q == size_w) ? '0 : ptr_q;

	// test unit: free bits of the current word inside the scan window
	always_comb begin
		cand = '0;
		for (int b = 0; b < WORD_W; b++) begin
			cand[b] = rdata_q[b] && (BIT_W'(b) >= start_q)
				&& ({word_q, BIT_W'(b)} < size_w);
		end
		hit_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
	end

	assign hit       = |cand;
	assign hit_idx   = {word_q, hit_bit};
	assign last_word = {({1'b0, word_q} + (WIDX_W+1)'(1)), {BIT_W{1'b0}}}
		>= {1'b0, size_w};

	// a response is loaded when a request finishes in this cycle
	assign rsp_load = ((state_q == S_IDLE) && accept
			&& ((req.func == FUNC_FREE) ? ({1'b0, req.slot_index} >= size_w)
				: (ptr_wrap >= size_w)))
		|| ((state_q == S_SCAN) && (hit || last_word))
		|| (state_q == S_FREE);

	// lookahead read: next word is fetched while the current one is tested
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_word = (req.func == FUNC_FREE) ? WIDX_W'(req.slot_index[SLOT_W-1:BIT_W])
				: ptr_wrap[PTR_W-1:BIT_W];
		end else begin
			rd_word = word_q + WIDX_W'(1);
		end
	end

	always_comb begin
		we = 1'b0;
		wa = AW'(word_q);
		wd = rdata_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '1;
			end
			S_SCAN: begin
				we = hit;
				wd = rdata_q & ~(WORD_W'(1) << hit_bit);
			end
			S_FREE: begin
				we = 1'b1;
				wd = rdata_q | (WORD_W'(1) << fbit_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[AW'(rd_word)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			pool_size_q <= PTR_W'(256);
			out_valid_q <= 1'b0;
			granted_q   <= '0;
			status_q    <= ST_OK;
			word_q      <= '0;
			start_q     <= '0;
			fbit_q      <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				pool_size_q <= cfg.pool_size;
			end
			out_valid_q <= rsp_load || (out_valid_q && !rsp.ready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NW - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						granted_q <= '0;
						if (req.func == FUNC_FREE) begin
							if ({1'b0, req.slot_index} < size_w) begin
								word_q  <= WIDX_W'(req.slot_index[SLOT_W-1:BIT_W]);
								fbit_q  <= req.slot_index[BIT_W-1:0];
								state_q <= S_FREE;
							end else begin
								status_q <= ST_RANGE;
							end
						end else begin
							ptr_q <= ptr_wrap;
							if (ptr_wrap < size_w) begin
								word_q  <= ptr_wrap[PTR_W-1:BIT_W];
								start_q <= ptr_wrap[BIT_W-1:0];
								state_q <= S_SCAN;
							end else begin
								status_q <= ST_EXHAUSTED;
							end
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						granted_q <= hit_idx[SLOT_W-1:0];
						status_q  <= ST_OK;
						ptr_q     <= hit_idx + PTR_W'(1);
						state_q   <= S_IDLE;
					end else if (last_word) begin
						status_q <= ST_EXHAUSTED;
						state_q  <= S_IDLE;
					end else begin
						word_q  <= word_q + WIDX_W'(1);
						start_q <= '0;
					end
				end
				S_FREE: begin
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pointer never runs past the largest usable pool
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(SIZE_CAP))
		else $error("search pointer beyond pool capacity");

	// the output slot stays empty while a request is still being worked on
	a_scan_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_FREE) |-> !out_valid_q)
		else $error("response pending during scan or free");

	// a response only appears once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> state_q == S_IDLE)
		else $error("response raised outside idle");

	// a granted slot always lies inside the pool
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit) |-> hit_idx < size_w)
		else $error("grant outside pool");

endmodule

>>> tb/tb_next_fit_slot_allocator.sv
// self-checking testbench for the next-fit slot allocator with a predicting scoreboard
`timescale 1ns / 1ps

module tb_next_fit_slot_allocator;
	import nfsa_pkg::*;

	localparam int POOL_SLOTS  = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 94;

	typedef struct packed {
		logic [SLOT_W-1:0] granted;
		status_t           status;
	} slot_rsp_t;

	class slot_pool_scoreboard;
		bit [POOL_SLOTS-1:0] free_slots;
		logic [PTR_W-1:0]    scan_ptr;
		logic [PTR_W-1:0]    pool_size;
		slot_rsp_t           awaited_rsp[$];
		int                  errors;

		function new();
			free_slots = '1;
			scan_ptr = '0;
			pool_size = 9'd256;
			errors = 0;
		endfunction

		function int unsigned usable_slots();
			return (pool_size < POOL_SLOTS) ? pool_size : POOL_SLOTS;
		endfunction

		function int pending();
			return awaited_rsp.size();
		endfunction

		// next-fit: the scan never goes below the pointer, it only wraps at the exact size
		function void note_request(logic func, logic [SLOT_W-1:0] idx);
			int unsigned lim;
			slot_rsp_t want;
			lim = usable_slots();
			want.granted = '0;
			want.status = ST_OK;
			if (func == FUNC_ALLOC) begin
				if (scan_ptr == lim)
					scan_ptr = '0;
				want.status = ST_EXHAUSTED;
				for (int i = scan_ptr; i < lim; i++) begin
					if (free_slots[i]) begin
						free_slots[i] = 1'b0;
						scan_ptr = PTR_W'(i + 1);
						want.granted = SLOT_W'(i);
						want.status = ST_OK;
						break;
					end
				end
			end else if (idx < lim) begin
				free_slots[idx] = 1'b1;
			end else begin
				want.status = ST_RANGE;
			end
			awaited_rsp.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_response(logic [SLOT_W-1:0] granted, status_t status);
			slot_rsp_t want;
			if (awaited_rsp.size() == 0) begin
				report($sformatf("beat granted=%0d status=%0d with no request outstanding",
					granted, status));
				return;
			end
			want = awaited_rsp.pop_front();
			if (granted !== want.granted)
				report($sformatf("granted_index %0d, predicted %0d", granted, want.granted));
			if (status !== want.status)
				report($sformatf("status %0d, predicted %0d", status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;

	nfsa_req_if req_ch();
	nfsa_rsp_if rsp_ch();
	nfsa_cfg_if cfg_ch();

	next_fit_slot_allocator #(.MAX_SLOTS(POOL_SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	slot_pool_scoreboard sb;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	int phase_sizes[PHASES] = '{256, 16, 1, 511, 0, 37, 2, 300, 128, 255, 5, 256};
	int idle_pcts[4]  = '{0, 67, 0, 11};
	int stall_pcts[4] = '{0, 0, 67, 11};

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.granted_index, rsp_ch.status);
	end

	// any beat on any channel counts as progress
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_next_fit_slot_allocator: errors");
			$finish;
		end
	end

	task automatic send_request(logic f, logic [SLOT_W-1:0] idx);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.slot_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(f, idx);
	endtask

	task automatic drain_requests();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// pool size only changes with nothing in flight
	task automatic write_pool_size(logic [PTR_W-1:0] size);
		drain_requests();
		cfg_ch.valid <= 1'b1;
		cfg_ch.pool_size <= size;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.pool_size = size;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [PTR_W-1:0] size, int idle_pct, int stall_pct, int count);
		int unsigned lim;
		logic f;
		logic [SLOT_W-1:0] idx;
		write_pool_size(size);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		lim = sb.usable_slots();
		repeat (count) begin
			// now and then hold off until the block has answered everything
			if ($urandom_range(99) == 0)
				drain_requests();
			f = ($urandom_range(99) < 55) ? FUNC_ALLOC : FUNC_FREE;
			if (lim != 0 && $urandom_range(99) < 80)
				idx = SLOT_W'($urandom_range(lim - 1, 0));
			else
				idx = SLOT_W'($urandom);
			send_request(f, idx);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ALLOC;
		req_ch.slot_index = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pool_size = 9'd256;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// full pool: grants in order, frees behind the pointer are not reused yet
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_ALLOC, 8'd255);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd1);
		send_request(FUNC_FREE, 8'd255);
		send_request(FUNC_FREE, 8'd0);
		send_request(FUNC_ALLOC, 8'd0);
		// pointer equal to the size wraps to the bottom
		write_pool_size(9'd4);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd4);
		send_request(FUNC_FREE, 8'd3);
		send_request(FUNC_ALLOC, 8'd0);
		// pointer left above a shrunken pool
		write_pool_size(9'd2);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd1);
		send_request(FUNC_ALLOC, 8'd0);
		write_pool_size(9'd0);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd0);
		// size beyond the map is clipped to the map
		write_pool_size(9'd511);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd255);
		send_request(FUNC_ALLOC, 8'd0);
		write_pool_size(9'd1);
		send_request(FUNC_ALLOC, 8'd0);
		send_request(FUNC_FREE, 8'd0);

		for (int p = 0; p < PHASES; p++)
			run_phase(PTR_W'(phase_sizes[p]), idle_pcts[p % 4], stall_pcts[p % 4],
				PHASE_ITEMS);

		drain_requests();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_next_fit_slot_allocator: clean");
		else
			$display("tb_next_fit_slot_allocator: errors");
		$finish;
	end

endmodule
